@@ hdl/assert_macros.svh @@
// Assertion macros shared by the conditional block stack modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge, held off while reset is asserted.
`define CBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define CBS_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CBS_ASSERT(label, prop, msg)
`define CBS_ASSERT_ALL(label, prop, msg)
`endif
`endif

@@ hdl/cbs_pkg.sv @@
// Shared types and codes for the conditional block stack.
`timescale 1ns / 1ps
package cbs_pkg;

    typedef enum logic [2:0] {
        ACT_OPEN  = 3'd0,
        ACT_ELIF  = 3'd1,
        ACT_ELSE  = 3'd2,
        ACT_ENDIF = 3'd3,
        ACT_CHECK = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_NO_BLOCK        = 3'd1,
        ST_ELIF_AFTER_ELSE = 3'd2,
        ST_ELSE_AFTER_ELSE = 3'd3,
        ST_OVERFLOW        = 3'd4,
        ST_UNCLOSED        = 3'd5
    } t_status;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 6;

    // One stack frame: bit 0 active, bit 1 taken, bit 2 else seen.
    typedef struct packed {
        logic else_seen;
        logic taken;
        logic active;
    } t_frame;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input beat and read the top frame
        logic commit;   // apply the command and load the result register
    } t_dp_cmd;

endpackage

@@ hdl/conditional_block_stack.sv @@
// Top level of the conditional block stack.
//
// Tracks nested conditional-compilation blocks (ifdef/ifndef, elif, else,
// endif) as a stack of three-bit frames, and answers each command beat with
// a status code, whether tokens may pass, and the nesting depth after the
// step. Each command has a take cycle, in which its beat is taken and the
// top frame is read from the stack memory through its registered read port,
// and an execute cycle that updates the top frame, the open count and the
// inactive count, and loads the result register. The next beat is taken in
// the cycle after execute; no new beat is taken while a command
// executes. The result register lets the next command be
// taken and read while a result still waits downstream; execute holds until
// that register is free. A push onto a full stack returns overflow and
// changes nothing. Stack frames are not cleared at reset: only frames below
// the open count are ever used. nest_depth carries the low six bits of the
// open count.
`timescale 1ns / 1ps
module conditional_block_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cbs_pkg::ACTION_W-1:0]  i_action,
    input  logic                          i_is_defined,
    input  logic                          i_negate,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cbs_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_pass_tokens,
    output logic [cbs_pkg::DEPTH_W-1:0]   o_nest_depth
);

    cbs_pkg::t_dp_cmd w_cmd;

    // Sequence each beat: take, read top frame, execute, hold result.
    cbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Hold the frame stack, the two counters and the result status.
    cbs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (i_action),
        .i_is_defined  (i_is_defined),
        .i_negate      (i_negate),
        .o_status      (o_status),
        .o_pass_tokens (o_pass_tokens),
        .o_nest_depth  (o_nest_depth)
    );

endmodule

@@ hdl/cbs_ctrl.sv @@
// Handshake controller for the conditional block stack.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cbs_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_capture;
    logic   w_commit;

    assign w_capture = i_in_valid && r_in_ready;
    // Commit only when the result register is free or drains this cycle.
    assign w_commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_in_ready <= 1'b1;
                    if (w_capture) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready      = r_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_cmd.capture   = w_capture;
    assign o_cmd.commit    = w_commit;

    `CBS_ASSERT(a_accept_to_exec, w_capture |=> (r_state == S_EXEC), "accepted beat did not start execution")
    `CBS_ASSERT(a_no_ready_in_exec, (r_state == S_EXEC) |-> !r_in_ready, "ready high while busy")
    `CBS_ASSERT(a_result_from_exec, $rose(r_out_valid) |-> $past(r_state == S_EXEC), "result appeared without execution")

endmodule

@@ hdl/cbs_datapath.sv @@
// Frame stack, counters and result register of the conditional block stack.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbs_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbs_pkg::t_dp_cmd                    i_cmd,
    input  logic [cbs_pkg::ACTION_W-1:0]        i_action,
    input  logic                                i_is_defined,
    input  logic                                i_negate,
    output logic [cbs_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_pass_tokens,
    output logic [cbs_pkg::DEPTH_W-1:0]         o_nest_depth
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    cbs_pkg::t_frame                    r_mem [STACK_DEPTH];
    cbs_pkg::t_frame                    r_top;
    logic [cbs_pkg::ACTION_W-1:0]       r_action;
    logic                               r_cond;
    logic [CW-1:0]                      r_open;
    logic [CW-1:0]                      r_inact;
    logic [cbs_pkg::STATUS_W-1:0]       r_status;

    logic [CW-1:0]                      n_open;
    logic [CW-1:0]                      n_inact;
    cbs_pkg::t_status                   n_status;
    logic                               w_wr_en;
    logic [AW-1:0]                      w_wr_addr;
    cbs_pkg::t_frame                    w_wr_data;
    logic [AW-1:0]                      w_top_addr;
    logic                               w_empty;
    logic                               w_full;
    cbs_pkg::t_frame                    w_next;

    assign w_top_addr = AW'(r_open - CW'(1));
    assign w_empty    = (r_open == '0);
    assign w_full     = (r_open == CW'(STACK_DEPTH));

    // Stack memory: one write port, one registered read of the top frame.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_top <= r_mem[w_top_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_cond   <= i_is_defined ^ i_negate;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= '0;
            r_inact <= '0;
        end else if (i_cmd.commit) begin
            r_open  <= n_open;
            r_inact <= n_inact;
        end
    end

    always_comb begin
        n_open    = r_open;
        n_inact   = r_inact;
        n_status  = cbs_pkg::ST_OK;
        w_wr_en   = 1'b0;
        w_wr_addr = w_top_addr;
        w_wr_data = r_top;
        w_next    = r_top;
        case (r_action)
            cbs_pkg::ACT_OPEN: begin
                if (w_full) begin
                    n_status = cbs_pkg::ST_OVERFLOW;
                end else begin
                    w_wr_en   = i_cmd.commit;
                    w_wr_addr = AW'(r_open);
                    w_wr_data = '{else_seen: 1'b0, taken: 1'b0, active: r_cond};
                    n_open    = r_open + CW'(1);
                    if (!r_cond) begin
                        n_inact = r_inact + CW'(1);
                    end
                end
            end
            cbs_pkg::ACT_ELIF, cbs_pkg::ACT_ELSE: begin
                if (w_empty) begin
                    n_status = cbs_pkg::ST_NO_BLOCK;
                end else if (r_top.else_seen) begin
                    n_status = (r_action == cbs_pkg::ACT_ELIF) ?
                               cbs_pkg::ST_ELIF_AFTER_ELSE : cbs_pkg::ST_ELSE_AFTER_ELSE;
                end else begin
                    // Leave the running branch; enter the new one if none was taken.
                    if (r_top.active) begin
                        w_next.active = 1'b0;
                        w_next.taken  = 1'b1;
                    end
                    if (r_action == cbs_pkg::ACT_ELSE) begin
                        w_next.else_seen = 1'b1;
                        if (!w_next.taken) begin
                            w_next.active = 1'b1;
                        end
                    end else if (!w_next.taken && r_cond) begin
                        w_next.active = 1'b1;
                    end
                    w_wr_en   = i_cmd.commit;
                    w_wr_data = w_next;
                    if (r_top.active && !w_next.active) begin
                        n_inact = r_inact + CW'(1);
                    end else if (!r_top.active && w_next.active) begin
                        n_inact = r_inact - CW'(1);
                    end
                end
            end
            cbs_pkg::ACT_ENDIF: begin
                if (w_empty) begin
                    n_status = cbs_pkg::ST_NO_BLOCK;
                end else begin
                    n_open = r_open - CW'(1);
                    if (!r_top.active) begin
                        n_inact = r_inact - CW'(1);
                    end
                end
            end
            cbs_pkg::ACT_CHECK: begin
                if (!w_empty) begin
                    n_status = cbs_pkg::ST_UNCLOSED;
                end
            end
            default: begin
                n_status = cbs_pkg::ST_OK;
            end
        endcase
    end

    assign o_status      = r_status;
    assign o_pass_tokens = (r_inact == '0);
    assign o_nest_depth  = cbs_pkg::DEPTH_W'(r_open);

    `CBS_ASSERT(a_inact_le_open, r_inact <= r_open, "more inactive frames than open frames")
    `CBS_ASSERT(a_depth_bound, r_open <= CW'(STACK_DEPTH), "stack depth out of range")
    `CBS_ASSERT(a_full_push_refused, (i_cmd.commit && w_full && (r_action == cbs_pkg::ACT_OPEN)) |=> $stable(r_open), "push taken on a full stack")

endmodule

@@ verif/nest_checker.sv @@
// Predictor and result checker for the conditional block stack.
`timescale 1ns / 1ps
module nest_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [cbs_pkg::ACTION_W-1:0] i_action,
    input  logic                         i_is_defined,
    input  logic                         i_negate,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [cbs_pkg::STATUS_W-1:0] i_status,
    input  logic                         i_pass_tokens,
    input  logic [cbs_pkg::DEPTH_W-1:0]  i_nest_depth,
    output int                           o_mismatches,
    output int                           o_pending
);

    typedef struct {
        cbs_pkg::t_status            status;
        logic                        pass_tokens;
        logic [cbs_pkg::DEPTH_W-1:0] nest_depth;
    } t_answer;

    cbs_pkg::t_frame frames [STACK_DEPTH];
    int              open_cnt;
    int              inactive_cnt;
    t_answer         answer_q [$];
    t_answer         want;

    initial o_mismatches = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (o_mismatches < 200)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
        o_mismatches++;
    endtask

    // Replace the top frame, keeping the inactive count in step.
    function automatic void write_top(cbs_pkg::t_frame nxt);
        cbs_pkg::t_frame prev;
        prev = frames[open_cnt-1];
        if (prev.active && !nxt.active)
            inactive_cnt++;
        else if (!prev.active && nxt.active)
            inactive_cnt--;
        frames[open_cnt-1] = nxt;
    endfunction

    // Advance the stack by one directive and return the answer it gives.
    function automatic t_answer nest_step(logic [cbs_pkg::ACTION_W-1:0] act, logic cond);
        t_answer         a;
        cbs_pkg::t_frame f;
        a.status = cbs_pkg::ST_OK;
        case (act)
            cbs_pkg::ACT_OPEN: begin
                if (open_cnt >= STACK_DEPTH) begin
                    a.status = cbs_pkg::ST_OVERFLOW;
                end else begin
                    frames[open_cnt] = '{else_seen: 1'b0, taken: 1'b0, active: cond};
                    open_cnt++;
                    if (!cond)
                        inactive_cnt++;
                end
            end
            cbs_pkg::ACT_ELIF: begin
                if (open_cnt == 0) begin
                    a.status = cbs_pkg::ST_NO_BLOCK;
                end else begin
                    f = frames[open_cnt-1];
                    if (f.else_seen) begin
                        a.status = cbs_pkg::ST_ELIF_AFTER_ELSE;
                    end else begin
                        if (f.active) begin
                            f.active = 1'b0;
                            f.taken  = 1'b1;
                        end
                        if (!f.taken && cond)
                            f.active = 1'b1;
                        write_top(f);
                    end
                end
            end
            cbs_pkg::ACT_ELSE: begin
                if (open_cnt == 0) begin
                    a.status = cbs_pkg::ST_NO_BLOCK;
                end else begin
                    f = frames[open_cnt-1];
                    if (f.else_seen) begin
                        a.status = cbs_pkg::ST_ELSE_AFTER_ELSE;
                    end else begin
                        if (f.active) begin
                            f.active = 1'b0;
                            f.taken  = 1'b1;
                        end
                        f.else_seen = 1'b1;
                        if (!f.taken)
                            f.active = 1'b1;
                        write_top(f);
                    end
                end
            end
            cbs_pkg::ACT_ENDIF: begin
                if (open_cnt == 0) begin
                    a.status = cbs_pkg::ST_NO_BLOCK;
                end else begin
                    if (!frames[open_cnt-1].active)
                        inactive_cnt--;
                    open_cnt--;
                end
            end
            cbs_pkg::ACT_CHECK: begin
                a.status = (open_cnt != 0) ? cbs_pkg::ST_UNCLOSED : cbs_pkg::ST_OK;
            end
            default: ;
        endcase
        a.pass_tokens = (inactive_cnt == 0);
        a.nest_depth  = open_cnt[cbs_pkg::DEPTH_W-1:0];
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_cnt     = 0;
            inactive_cnt = 0;
            answer_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                answer_q.push_back(nest_step(i_action, i_is_defined ^ i_negate));
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result (status)", i_status, -1);
                end else begin
                    want = answer_q.pop_front();
                    if (i_status != want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_pass_tokens != want.pass_tokens)
                        report_mismatch("pass_tokens", i_pass_tokens, want.pass_tokens);
                    if (i_nest_depth != want.nest_depth)
                        report_mismatch("nest_depth", i_nest_depth, want.nest_depth);
                end
            end
        end
        o_pending = answer_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the conditional block stack: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int STACK_DEPTH  = 32;
    localparam int ITEMS        = 1600;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_GAP      = 12;

    // Action codes the block has no meaning for; it must answer ok and hold state.
    localparam logic [cbs_pkg::ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [cbs_pkg::ACTION_W-1:0] ACT_UNUSED_MID   = 3'd6;
    localparam logic [cbs_pkg::ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    // Stimulus shapes for the random part.
    typedef enum int {
        MODE_WALK,   // well-formed nesting around a target depth
        MODE_FILL,   // open until full, push past the top, then unwind
        MODE_NOISE   // any code, any field
    } t_mode;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [cbs_pkg::ACTION_W-1:0] action = '0;
    logic                         is_defined = 1'b0;
    logic                         negate = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [cbs_pkg::STATUS_W-1:0] status;
    logic                         pass_tokens;
    logic [cbs_pkg::DEPTH_W-1:0]  nest_depth;

    int mismatches;
    int pending;
    int cycles = 0;

    // Shared idling controls: no_idle gives stretches with back-to-back beats on
    // both sides; hold_request asks the result side for one long hold-off.
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    // Shadow of depth and else-seen flags, used only to steer the generator
    // toward well-formed sequences. Updated for every issued directive.
    int depth_sh = 0;
    bit else_sh [STACK_DEPTH];

    conditional_block_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (action),
        .i_is_defined  (is_defined),
        .i_negate      (negate),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_pass_tokens (pass_tokens),
        .o_nest_depth  (nest_depth)
    );

    nest_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_action      (action),
        .i_is_defined  (is_defined),
        .i_negate      (negate),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_pass_tokens (pass_tokens),
        .i_nest_depth  (nest_depth),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one directive beat. Inputs move on the falling edge only; valid is
    // dropped only for a real gap, so a back-to-back beat keeps it high and just
    // swaps the payload. Return once the beat is taken at a rising edge.
    task automatic send_beat(input logic [cbs_pkg::ACTION_W-1:0] act, input logic def,
                             input logic neg);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action     = act;
        is_defined = def;
        negate     = neg;
        in_valid   = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Track the shadow stack, then send.
    task automatic issue(input logic [cbs_pkg::ACTION_W-1:0] act, input logic def,
                         input logic neg);
        case (act)
            cbs_pkg::ACT_OPEN: begin
                if (depth_sh < STACK_DEPTH) begin
                    else_sh[depth_sh] = 1'b0;
                    depth_sh++;
                end
            end
            cbs_pkg::ACT_ELSE: if (depth_sh > 0) else_sh[depth_sh-1] = 1'b1;
            cbs_pkg::ACT_ENDIF: if (depth_sh > 0) depth_sh--;
            default: ;
        endcase
        send_beat(act, def, neg);
    endtask

    // Result side: draw a stall per beat, then keep ready high until a result
    // is taken. A hold request parks ready low for a long count of its own, so
    // the block backs up and refuses further commands.
    initial begin : result_sink
        int stall;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        t_mode                        mode;
        logic [cbs_pkg::ACTION_W-1:0] act;
        logic                         def;
        logic                         neg;
        int                           counted;
        int                           episode_left;
        int                           target;
        int                           full_hits;
        int                           r;
        bit                           fill_up;
        bit                           held;
        bit                           paused;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: commands on an empty stack and unused codes.
        issue(cbs_pkg::ACT_CHECK, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_ELIF, 1'b1, 1'b0);
        issue(cbs_pkg::ACT_ELSE, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_ENDIF, 1'b1, 1'b1);
        issue(ACT_UNUSED_FIRST, 1'b1, 1'b0);
        issue(ACT_UNUSED_LAST, 1'b0, 1'b1);
        // Ifdef taken, then an ifndef that is not; elif picks up the branch,
        // a second elif after a taken branch stays off, then else after it.
        issue(cbs_pkg::ACT_OPEN, 1'b1, 1'b0);
        issue(cbs_pkg::ACT_OPEN, 1'b1, 1'b1);
        issue(cbs_pkg::ACT_ELIF, 1'b0, 1'b1);
        issue(cbs_pkg::ACT_ELIF, 1'b1, 1'b0);
        issue(ACT_UNUSED_MID, 1'b1, 1'b1);
        issue(cbs_pkg::ACT_ELSE, 1'b1, 1'b1);
        // Elif and else after else are refused and leave the frame alone.
        issue(cbs_pkg::ACT_ELIF, 1'b1, 1'b0);
        issue(cbs_pkg::ACT_ELSE, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_CHECK, 1'b1, 1'b1);
        issue(cbs_pkg::ACT_ENDIF, 1'b0, 1'b0);
        // Ifdef not taken falls through to else.
        issue(cbs_pkg::ACT_OPEN, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_ELSE, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_ENDIF, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_ENDIF, 1'b0, 1'b0);
        issue(cbs_pkg::ACT_CHECK, 1'b0, 1'b0);

        // Random part, in episodes. The first one fills the stack to overflow.
        counted      = 0;
        mode         = MODE_FILL;
        fill_up      = 1'b1;
        full_hits    = 0;
        episode_left = 0;
        target       = 4;
        held         = 1'b0;
        paused       = 1'b0;
        while (counted < ITEMS) begin
            if (mode != MODE_FILL && episode_left == 0) begin
                r            = $urandom_range(0, 99);
                mode         = (r < 70) ? MODE_WALK : (r < 85) ? MODE_FILL : MODE_NOISE;
                episode_left = $urandom_range(20, 60);
                target       = ($urandom_range(0, 9) == 0) ? STACK_DEPTH
                                                            : $urandom_range(1, 8);
                no_idle      = ($urandom_range(0, 3) == 0);
                fill_up      = 1'b1;
                full_hits    = 0;
            end

            def = 1'($urandom_range(0, 1));
            neg = 1'($urandom_range(0, 1));
            r   = $urandom_range(0, 99);
            case (mode)
                MODE_NOISE: begin
                    act = cbs_pkg::ACTION_W'($urandom_range(cbs_pkg::ACT_OPEN,
                                                            ACT_UNUSED_LAST));
                end
                MODE_FILL: begin
                    if (fill_up) begin
                        if (depth_sh == STACK_DEPTH) begin
                            act = cbs_pkg::ACT_OPEN;
                            full_hits++;
                            if (full_hits >= 2)
                                fill_up = 1'b0;
                        end else if (depth_sh > 0 && !else_sh[depth_sh-1] && r < 8) begin
                            act = (r < 4) ? cbs_pkg::ACT_ELIF : cbs_pkg::ACT_ELSE;
                        end else begin
                            act = cbs_pkg::ACT_OPEN;
                        end
                    end else if (depth_sh > 0 && !else_sh[depth_sh-1] && r < 25) begin
                        act = (r < 12) ? cbs_pkg::ACT_ELIF : cbs_pkg::ACT_ELSE;
                    end else begin
                        act = (r > 95) ? cbs_pkg::ACT_CHECK : cbs_pkg::ACT_ENDIF;
                    end
                end
                default: begin
                    if (r < 6)
                        act = cbs_pkg::ACT_CHECK;
                    else if (depth_sh == 0 || (depth_sh < target && r < 50))
                        act = cbs_pkg::ACT_OPEN;
                    else if (!else_sh[depth_sh-1] && r < 70)
                        act = cbs_pkg::ACT_ELIF;
                    else if (!else_sh[depth_sh-1] && r < 82)
                        act = cbs_pkg::ACT_ELSE;
                    else
                        act = cbs_pkg::ACT_ENDIF;
                end
            endcase

            issue(act, def, neg);
            if (act < ACT_UNUSED_FIRST)
                counted++;
            if (mode == MODE_FILL) begin
                if (!fill_up && depth_sh == 0)
                    mode = MODE_WALK;
            end else begin
                episode_left--;
            end

            // Back up the block: stall results for a long stretch while beats
            // keep coming, so the input side has to stall too.
            if (!held && counted >= 300) begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            // Drain completely once, then resume from an idle block.
            if (!paused && counted >= 900) begin
                paused = 1'b1;
                @(negedge clk);
                in_valid = 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        // Allow a stray late result to show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cbs_pkg.sv
hdl/cbs_ctrl.sv
hdl/cbs_datapath.sv
hdl/conditional_block_stack.sv
verif/nest_checker.sv
verif/tb_top.sv
